FILE: design/magic_length_frame_deframer_defines.svh
// Shared assertion shorthands for the deframer modules.
// Every use expects clk_i and rst_ni in the enclosing module.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define MLFD_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("deframer invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define MLFD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer sequence check failed");

`endif

FILE: design/mlfd_pkg.sv
package mlfd_pkg;

  localparam int unsigned HEADER_BYTES = 7;
  localparam int unsigned HDR_POS_W    = 3;

  localparam logic [7:0] MAGIC_FIRST  = 8'h4E;
  localparam logic [7:0] MAGIC_SECOND = 8'h44;

  // Header byte positions; zero means hunting for the first magic byte.
  localparam logic [HDR_POS_W-1:0] HDR_MAGIC0  = 3'd0;
  localparam logic [HDR_POS_W-1:0] HDR_MAGIC1  = 3'd1;
  localparam logic [HDR_POS_W-1:0] HDR_VERSION = 3'd2;
  localparam logic [HDR_POS_W-1:0] HDR_LEN0    = 3'd3;
  localparam logic [HDR_POS_W-1:0] HDR_LAST    = HDR_POS_W'(HEADER_BYTES - 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_EXPECTED_VERSION     = 2'd0;
  localparam logic [1:0] REG_UDP_MODE             = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD_STREAM   = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD_DATAGRAM = 2'd3;

  typedef enum logic [2:0] {
    ST_PAYLOAD     = 3'd0,
    ST_ACCEPTED    = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_TOO_LONG    = 3'd3,
    ST_BAD_MAGIC   = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic        udp_mode;
    logic [31:0] max_payload_stream;
    logic [31:0] max_payload_datagram;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  data_byte;
    logic [31:0] frame_length;
    logic [7:0]  frame_version;
    logic        last_of_frame;
  } res_t;

endpackage

FILE: design/mlfd_cfg_regs.sv
module mlfd_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output mlfd_pkg::cfg_t cfg_o
);
  import mlfd_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_EXPECTED_VERSION:     cfg_d.expected_version     = cfg_data_i[7:0];
        REG_UDP_MODE:             cfg_d.udp_mode             = cfg_data_i[0];
        REG_MAX_PAYLOAD_STREAM:   cfg_d.max_payload_stream   = cfg_data_i;
        REG_MAX_PAYLOAD_DATAGRAM: cfg_d.max_payload_datagram = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_version     <= 8'd1;
      cfg_q.udp_mode             <= 1'b0;
      cfg_q.max_payload_stream   <= 32'd1048576;
      cfg_q.max_payload_datagram <= 32'd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: design/mlfd_parser.sv
`include "magic_length_frame_deframer_defines.svh"

module mlfd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  output logic           rx_stall_o,
  input  logic [7:0]     rx_byte_i,
  input  mlfd_pkg::cfg_t cfg_i,
  input  logic           load_ok_i,
  output logic           res_valid_o,
  output mlfd_pkg::res_t res_o
);
  import mlfd_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           in_byte_q;
  logic                 advance;
  logic                 in_take;

  logic [HDR_POS_W-1:0] hp_q, hp_d;
  logic [31:0]          length_q, length_d;
  logic [7:0]           version_q, version_d;
  logic [31:0]          remaining_q, remaining_d;
  logic                 skip_q, skip_d;

  logic [31:0]          rem_dec;
  logic [1:0]           lane;
  logic [31:0]          length_full;
  logic [31:0]          limit;
  logic                 res_valid_c;
  res_t                 res_c;

  // Advance the held byte once the output side can take its result.
  assign advance    = in_valid_q && load_ok_i;
  assign in_take    = !in_valid_q || load_ok_i;
  assign rx_stall_o = !in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= rx_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && rx_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  assign rem_dec     = remaining_q - 32'd1;
  assign lane        = 2'(hp_q - HDR_LEN0);
  assign length_full = length_q | (32'(in_byte_q) << {lane, 3'b000});
  assign limit       = cfg_i.udp_mode ? cfg_i.max_payload_datagram
                                      : cfg_i.max_payload_stream;

  always_comb begin
    hp_d        = hp_q;
    length_d    = length_q;
    version_d   = version_q;
    remaining_d = remaining_q;
    skip_d      = skip_q;
    res_valid_c = 1'b0;
    res_c       = '0;
    res_c.status = ST_PAYLOAD;

    if (remaining_q != 32'd0) begin
      remaining_d = rem_dec;
      if (skip_q) begin
        if (rem_dec == 32'd0) begin
          skip_d = 1'b0;
        end
      end else begin
        res_valid_c         = 1'b1;
        res_c.data_byte     = in_byte_q;
        res_c.last_of_frame = (rem_dec == 32'd0);
      end
    end else begin
      case (hp_q)
        HDR_MAGIC0: begin
          if (in_byte_q == MAGIC_FIRST) begin
            hp_d = HDR_MAGIC1;
          end else begin
            res_valid_c  = 1'b1;
            res_c.status = ST_BAD_MAGIC;
          end
        end
        HDR_MAGIC1: begin
          if (in_byte_q == MAGIC_SECOND) begin
            hp_d = HDR_VERSION;
          end else begin
            hp_d         = HDR_MAGIC0;
            res_valid_c  = 1'b1;
            res_c.status = ST_BAD_MAGIC;
          end
        end
        HDR_VERSION: begin
          version_d = in_byte_q;
          length_d  = 32'd0;
          hp_d      = HDR_LEN0;
        end
        default: begin
          length_d = length_full;
          if (hp_q != HDR_LAST) begin
            hp_d = hp_q + 1'b1;
          end else begin
            hp_d                = HDR_MAGIC0;
            remaining_d         = length_full;
            res_valid_c         = 1'b1;
            res_c.frame_length  = length_full;
            res_c.frame_version = version_q;
            if (version_q != cfg_i.expected_version) begin
              res_c.status = ST_BAD_VERSION;
              skip_d       = (length_full != 32'd0);
            end else if (length_full > limit) begin
              res_c.status = ST_TOO_LONG;
              skip_d       = (length_full != 32'd0);
            end else begin
              res_c.status        = ST_ACCEPTED;
              skip_d              = 1'b0;
              res_c.last_of_frame = (length_full == 32'd0);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= HDR_MAGIC0;
      length_q    <= 32'd0;
      version_q   <= 8'd0;
      remaining_q <= 32'd0;
      skip_q      <= 1'b0;
    end else if (advance) begin
      hp_q        <= hp_d;
      length_q    <= length_d;
      version_q   <= version_d;
      remaining_q <= remaining_d;
      skip_q      <= skip_d;
    end
  end

  assign res_valid_o = advance && res_valid_c;
  assign res_o       = res_c;

  `MLFD_ASSERT_ALWAYS(a_skip_has_bytes, !skip_q || (remaining_q != 32'd0))
  `MLFD_ASSERT_ALWAYS(a_payload_at_hunt, (remaining_q == 32'd0) || (hp_q == HDR_MAGIC0))
  `MLFD_ASSERT_ALWAYS(a_pos_in_header, hp_q <= HDR_LAST)
  `MLFD_ASSERT_NEXT(a_held_byte_kept, in_valid_q && !load_ok_i, in_valid_q && $stable(in_byte_q))

endmodule

FILE: design/mlfd_out_reg.sv
module mlfd_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  input  mlfd_pkg::res_t res_i,
  output logic           load_ok_o,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output mlfd_pkg::res_t res_o
);
  import mlfd_pkg::*;

  logic valid_q;
  res_t res_q;

  // Load whenever the register is empty or its item leaves this cycle.
  assign load_ok_o   = !valid_q || !res_stall_i;
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ok_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: design/magic_length_frame_deframer.sv
// Length-prefixed frame deframer: takes one received byte per item and
// parses frames made of a 7-byte header (magic 0x4E 0x44, a version byte,
// a little-endian 32-bit payload length) and the payload that follows.
// A header is accepted when its version matches expected_version and its
// length does not exceed the limit of the selected mode (udp_mode picks
// max_payload_datagram, else max_payload_stream). Accepted payload bytes
// come out with status 0, the final one marked last_of_frame; an accepted
// empty frame marks its header result last. A wrong magic byte yields a bad
// magic result and hunting restarts; a rejected header reports bad version
// (checked first) or too long, and its payload is dropped without results.
// Correct header bytes other than the seventh produce nothing. The block
// takes one byte every clock cycle with no bubbles while the result side
// does not stall: each byte is held in an input register, parsed by one
// pass of compare/add logic against the header state, and its result lands
// in an output register. That register loads when the parser advances the
// held byte, and it drives the result onto the outputs until it is taken.
// A stall on the result side backs up into rx_stall_o after those two
// registers fill. Configuration writes are always ready and take effect
// once registered; write them only while the block is idle.
module magic_length_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,

  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  data_byte_o,
  output logic [31:0] frame_length_o,
  output logic [7:0]  frame_version_o,
  output logic        last_of_frame_o,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import mlfd_pkg::*;

  cfg_t cfg;
  res_t parse_res;
  res_t out_res;
  logic parse_valid;
  logic load_ok;

  // Hold the four configuration registers.
  mlfd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Register the incoming byte and run the header/payload parse on it.
  mlfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg),
    .load_ok_i   (load_ok),
    .res_valid_o (parse_valid),
    .res_o       (parse_res)
  );

  // Hold each result item until the downstream side takes it.
  mlfd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (parse_valid),
    .res_i       (parse_res),
    .load_ok_o   (load_ok),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (out_res)
  );

  assign status_o        = out_res.status;
  assign data_byte_o     = out_res.data_byte;
  assign frame_length_o  = out_res.frame_length;
  assign frame_version_o = out_res.frame_version;
  assign last_of_frame_o = out_res.last_of_frame;

endmodule
